[rtl/core/bcbc_pkg.sv]
// ----------------------------------------------------------------------------
// bcbc_pkg
// Shared types and constants for the bracket and comment balance checker.
// ----------------------------------------------------------------------------
package bcbc_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int KIND_W      = 2;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    localparam logic [KIND_W-1:0] KIND_PAREN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BRACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMMENT = 2'd2;

    localparam logic [2:0] VC_OK          = 3'd0;
    localparam logic [2:0] VC_BAD_PAREN   = 3'd1;
    localparam logic [2:0] VC_BAD_BRACK   = 3'd2;
    localparam logic [2:0] VC_BAD_COMMENT = 3'd3;
    localparam logic [2:0] VC_OPEN_PAREN  = 3'd4;
    localparam logic [2:0] VC_OPEN_BRACK  = 3'd5;
    localparam logic [2:0] VC_OPEN_COMMENT = 3'd6;
    localparam logic [2:0] VC_OVERFLOW    = 3'd7;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic       balanced;
        logic [2:0] verdict_code;
    } t_out_item;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic [KIND_W-1:0] kind;
    } t_stack_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [KIND_W-1:0] top;
    } t_stack_view;

endpackage

[rtl/core/bcbc_ram.sv]
// ----------------------------------------------------------------------------
// bcbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bcbc_stack.sv]
// ----------------------------------------------------------------------------
// bcbc_stack
// Opener stack: top entry in a register, lower entries in RAM with the entry
// below the top prefetched every cycle so a pop need not wait for a RAM read.
// ----------------------------------------------------------------------------
module bcbc_stack (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bcbc_pkg::t_stack_cmd     i_cmd,
    output bcbc_pkg::t_stack_view    o_view,
    output bcbc_pkg::t_stack_view    o_next
);

    logic [bcbc_pkg::CNT_W-1:0]  r_count;
    logic [bcbc_pkg::CNT_W-1:0]  n_count;
    logic [bcbc_pkg::CNT_W-1:0]  w_count_op;
    logic [bcbc_pkg::CNT_W-1:0]  w_count_rd;
    logic [bcbc_pkg::KIND_W-1:0] r_top;
    logic [bcbc_pkg::KIND_W-1:0] n_top;
    logic                        r_byp_valid;
    logic [bcbc_pkg::KIND_W-1:0] r_byp_data;
    logic [bcbc_pkg::KIND_W-1:0] w_ram_q;
    logic [bcbc_pkg::KIND_W-1:0] w_below;
    logic                        w_we;
    logic [bcbc_pkg::ADDR_W-1:0] w_waddr;
    logic [bcbc_pkg::ADDR_W-1:0] w_raddr;

    assign w_below = r_byp_valid ? r_byp_data : w_ram_q;
    assign w_we    = i_cmd.push && (r_count != '0);

    always_comb begin
        w_count_op = r_count;
        n_top      = r_top;
        if (i_cmd.push) begin
            w_count_op = r_count + bcbc_pkg::CNT_W'(1);
            n_top      = i_cmd.kind;
        end else if (i_cmd.pop) begin
            w_count_op = r_count - bcbc_pkg::CNT_W'(1);
            n_top      = w_below;
        end
    end

    assign n_count    = i_cmd.clear ? '0 : w_count_op;
    assign w_count_rd = n_count - bcbc_pkg::CNT_W'(2);
    assign w_raddr    = w_count_rd[bcbc_pkg::ADDR_W-1:0];
    assign w_waddr    = w_count_op[bcbc_pkg::ADDR_W-1:0] - bcbc_pkg::ADDR_W'(2);

    bcbc_ram #(
        .WIDTH (bcbc_pkg::KIND_W),
        .DEPTH (bcbc_pkg::STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_top),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_byp_valid <= w_we;
        end
        r_top      <= n_top;
        r_byp_data <= r_top;
    end

    assign o_view.count = r_count;
    assign o_view.top   = r_top;
    assign o_next.count = w_count_op;
    assign o_next.top   = n_top;

endmodule

[rtl/core/bracket_comment_balance_checker.sv]
// ----------------------------------------------------------------------------
// bracket_comment_balance_checker
// Checks nesting of (), [] and comment tokens over a byte stream and gives
// one verdict on the byte marked last.
// ----------------------------------------------------------------------------
// A verdict reaches the output via the input register, then the result
// register, after the last byte's transfer.
// Throughput: one byte per cycle unless a last byte waits for the output; the
// top register and prefetched entry below it allow a push or pop every cycle.
// Reset clears stack count, token hold, error latch and both valid flags;
// stack RAM contents are not cleared and need no clearing pass.
module bracket_comment_balance_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bcbc_pkg::t_in_item    i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bcbc_pkg::t_out_item   o_out
);

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_SLASH,
        HOLD_STAR
    } t_hold;

    logic                  r_in_valid;
    bcbc_pkg::t_in_item    r_in;
    logic                  r_out_valid;
    bcbc_pkg::t_out_item   r_out;
    t_hold                 r_held;
    t_hold                 n_held;
    logic                  r_err;
    logic                  n_err;
    logic [2:0]            r_code;
    logic [2:0]            n_code;
    logic                  w_p_err;
    logic [2:0]            w_p_code;
    logic                  w_out_free;
    logic                  w_consume;
    logic                  w_want_push;
    logic                  w_want_pop;
    logic [bcbc_pkg::KIND_W-1:0] w_kind;
    logic [2:0]            w_bad_code;
    logic                  w_full;
    logic                  w_empty;
    logic [2:0]            w_verdict;
    bcbc_pkg::t_stack_cmd  w_cmd;
    bcbc_pkg::t_stack_view w_view;
    bcbc_pkg::t_stack_view w_next;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_consume  = r_in_valid && (!r_in.last || w_out_free);
    assign o_in_ready = !r_in_valid || w_consume;
    assign w_full     = (w_view.count == bcbc_pkg::CNT_W'(bcbc_pkg::STACK_DEPTH));
    assign w_empty    = (w_view.count == '0);

    always_comb begin
        w_want_push = 1'b0;
        w_want_pop  = 1'b0;
        w_kind      = bcbc_pkg::KIND_PAREN;
        w_bad_code  = bcbc_pkg::VC_OK;
        n_held      = r_held;
        if (w_consume && !r_err) begin
            n_held = HOLD_NONE;
            if (r_held == HOLD_SLASH && r_in.ch == bcbc_pkg::CH_STAR) begin
                w_want_push = 1'b1;
                w_kind      = bcbc_pkg::KIND_COMMENT;
            end else if (r_held == HOLD_STAR && r_in.ch == bcbc_pkg::CH_SLASH) begin
                w_want_pop = 1'b1;
                w_kind     = bcbc_pkg::KIND_COMMENT;
                w_bad_code = bcbc_pkg::VC_BAD_COMMENT;
            end else begin
                case (r_in.ch)
                    bcbc_pkg::CH_LPAREN: begin
                        w_want_push = 1'b1;
                        w_kind      = bcbc_pkg::KIND_PAREN;
                    end
                    bcbc_pkg::CH_LBRACK: begin
                        w_want_push = 1'b1;
                        w_kind      = bcbc_pkg::KIND_BRACK;
                    end
                    bcbc_pkg::CH_RPAREN: begin
                        w_want_pop = 1'b1;
                        w_kind     = bcbc_pkg::KIND_PAREN;
                        w_bad_code = bcbc_pkg::VC_BAD_PAREN;
                    end
                    bcbc_pkg::CH_RBRACK: begin
                        w_want_pop = 1'b1;
                        w_kind     = bcbc_pkg::KIND_BRACK;
                        w_bad_code = bcbc_pkg::VC_BAD_BRACK;
                    end
                    bcbc_pkg::CH_SLASH: n_held = HOLD_SLASH;
                    bcbc_pkg::CH_STAR:  n_held = HOLD_STAR;
                    default:            n_held = HOLD_NONE;
                endcase
            end
        end
        if (w_consume && r_in.last) begin
            n_held = HOLD_NONE;
        end
    end

    always_comb begin
        w_cmd.push  = w_want_push && !w_full;
        w_cmd.pop   = w_want_pop && !w_empty;
        w_cmd.clear = w_consume && r_in.last;
        w_cmd.kind  = w_kind;
        w_p_err     = r_err;
        w_p_code    = r_code;
        if (!r_err) begin
            if (w_want_push && w_full) begin
                w_p_err  = 1'b1;
                w_p_code = bcbc_pkg::VC_OVERFLOW;
            end else if (w_want_pop && (w_empty || w_view.top != w_kind)) begin
                w_p_err  = 1'b1;
                w_p_code = w_bad_code;
            end
        end
        n_err  = w_cmd.clear ? 1'b0 : w_p_err;
        n_code = w_cmd.clear ? bcbc_pkg::VC_OK : w_p_code;
    end

    always_comb begin
        if (w_p_err) begin
            w_verdict = w_p_code;
        end else if (w_next.count == '0) begin
            w_verdict = bcbc_pkg::VC_OK;
        end else begin
            unique case (w_next.top)
                bcbc_pkg::KIND_PAREN: w_verdict = bcbc_pkg::VC_OPEN_PAREN;
                bcbc_pkg::KIND_BRACK: w_verdict = bcbc_pkg::VC_OPEN_BRACK;
                default:              w_verdict = bcbc_pkg::VC_OPEN_COMMENT;
            endcase
        end
    end

    bcbc_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_view  (w_view),
        .o_next  (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held      <= HOLD_NONE;
            r_err       <= 1'b0;
            r_code      <= bcbc_pkg::VC_OK;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_cmd.clear) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_held <= n_held;
            r_err  <= n_err;
            r_code <= n_code;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_cmd.clear) begin
            r_out.balanced     <= (w_verdict == bcbc_pkg::VC_OK);
            r_out.verdict_code <= w_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_view.count <= bcbc_pkg::CNT_W'(bcbc_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.push, w_cmd.pop}))
        else $error("push and pop in the same cycle");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clear |=> (w_view.count == '0 && !r_err && r_held == HOLD_NONE))
        else $error("state not cleared after verdict");

    a_balanced_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.balanced == (o_out.verdict_code == bcbc_pkg::VC_OK)))
        else $error("balanced flag disagrees with verdict");
`endif

endmodule
